/* hw/rtl/ncts_pkg.sv */
`timescale 1ns / 1ps

package ncts_pkg;

    // Fixed field widths of the streaming and configuration ports
    localparam int ROW_BITS      = 64;
    localparam int MAX_WIDTH_DEF = 64;
    localparam int GRID_WIDTH_W  = 7;
    localparam int THRESH_W      = 4;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 7;

    // Neighbor count 0..8
    localparam int COUNT_W = 4;

    // Result queue depth, power of two so the pointers wrap naturally
    localparam int OUT_DEPTH = 4;

    localparam logic [GRID_WIDTH_W-1:0] GRID_WIDTH_RST = 7'd64;
    localparam logic [THRESH_W-1:0]     THRESH_RST     = 4'd5;

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRID_WIDTH      = 2'd0,
        REG_BIRTH_THRESHOLD = 2'd1
    } cfg_reg_t;

    // Per-cycle control broadcast to every cell of the row
    typedef struct packed {
        logic load;   // shift rows: upper <= middle, middle <= incoming
        logic clear;  // end of grid, drop both held rows
        logic flush;  // row below is outside the grid
    } cell_ctrl_t;

    // Result queue occupancy as seen by the control
    typedef struct packed {
        logic room_two;
        logic not_full;
    } fifo_status_t;

endpackage

/* hw/rtl/ncts_cell.sv */
`timescale 1ns / 1ps

// One grid column: holds the upper and middle row bits of that column,
// shows its masked bits to both neighbors and forms the next-generation bit.
module ncts_cell
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  ncts_pkg::cell_ctrl_t          ctrl,
    input  logic                          en,
    input  logic                          below_in,
    input  logic [ncts_pkg::THRESH_W-1:0] thresh,
    input  logic                          left_up,
    input  logic                          left_mid,
    input  logic                          left_low,
    input  logic                          right_up,
    input  logic                          right_mid,
    input  logic                          right_low,
    output logic                          up_tap,
    output logic                          mid_tap,
    output logic                          low_tap,
    output logic                          next_bit
);

    logic                         up_reg;
    logic                         mid_reg;
    logic                         up_next;
    logic                         mid_next;
    logic [ncts_pkg::COUNT_W-1:0] count;

    // Column taps, masked by the current grid width
    assign up_tap  = up_reg & en;
    assign mid_tap = mid_reg & en;
    assign low_tap = below_in & en & ~ctrl.flush;

    // Eight neighbors, own middle bit excluded
    always_comb
    begin
        count = ncts_pkg::COUNT_W'(left_up) + ncts_pkg::COUNT_W'(up_tap)
              + ncts_pkg::COUNT_W'(right_up) + ncts_pkg::COUNT_W'(left_mid)
              + ncts_pkg::COUNT_W'(right_mid) + ncts_pkg::COUNT_W'(left_low)
              + ncts_pkg::COUNT_W'(low_tap) + ncts_pkg::COUNT_W'(right_low);
    end

    assign next_bit = en & (count >= thresh);

    // Row shift
    always_comb
    begin
        up_next  = up_reg;
        mid_next = mid_reg;
        if (ctrl.clear)
        begin
            up_next  = 1'b0;
            mid_next = 1'b0;
        end
        else if (ctrl.load)
        begin
            up_next  = mid_reg;
            mid_next = below_in & en;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_reg  <= 1'b0;
            mid_reg <= 1'b0;
        end
        else
        begin
            up_reg  <= up_next;
            mid_reg <= mid_next;
        end
    end

endmodule

/* hw/rtl/ncts_out_fifo.sv */
`timescale 1ns / 1ps

// Small result queue; the head entry drives the output port directly.
module ncts_out_fifo
#(
    parameter int DATA_W = ncts_pkg::MAX_WIDTH_DEF + 1,
    parameter int DEPTH  = ncts_pkg::OUT_DEPTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  logic [DATA_W-1:0]      push_data,
    output logic                   pop_valid,
    input  logic                   pop_ready,
    output logic [DATA_W-1:0]      pop_data,
    output ncts_pkg::fifo_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              pop;

    assign pop       = pop_valid & pop_ready;
    assign pop_valid = (count_reg != '0);
    assign pop_data  = mem[rd_ptr_reg];

    assign status.room_two = (count_reg <= CNT_W'(DEPTH - 2));
    assign status.not_full = (count_reg < CNT_W'(DEPTH));

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* hw/rtl/neighbour_count_threshold_stencil.sv */
`timescale 1ns / 1ps

// One generation of a binary cave-generation automaton, streamed one grid row
// per request. Each column of the grid is a cell that holds its bits of the
// two buffered rows and counts the live cells among its eight neighbors
// against birth_threshold. A row is accepted every cycle while the input is
// not stalled; the result for the row before it enters a four-entry output
// queue in the same cycle, so a result appears one row late. A request with
// last_row set is followed by a flush state, in which no row is accepted,
// that emits the final result with frame_end set. Input stalls during the
// flush and when the output queue lacks room for two results. grid_width and
// birth_threshold are written over the cfg port (always ready) while idle;
// no clearing pass is needed after reset.
module neighbour_count_threshold_stencil
#(
    parameter int MAX_WIDTH = ncts_pkg::MAX_WIDTH_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [ncts_pkg::ROW_BITS-1:0]   row_cells,
    input  logic                            last_row,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [ncts_pkg::ROW_BITS-1:0]   next_row_cells,
    output logic                            frame_end,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ncts_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ncts_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int GW_W = ncts_pkg::GRID_WIDTH_W;

    logic [GW_W-1:0]               grid_width_reg;
    logic [GW_W-1:0]               grid_width_next;
    logic [ncts_pkg::THRESH_W-1:0] thresh_reg;
    logic [ncts_pkg::THRESH_W-1:0] thresh_next;
    logic                          held_reg;
    logic                          held_next;
    logic                          flush_reg;
    logic                          flush_next;

    logic                   in_fire;
    logic                   flush_fire;
    logic                   push;
    ncts_pkg::cell_ctrl_t   ctrl;
    ncts_pkg::fifo_status_t fifo_st;

    logic [MAX_WIDTH-1:0] up_tap;
    logic [MAX_WIDTH-1:0] mid_tap;
    logic [MAX_WIDTH-1:0] low_tap;
    logic [MAX_WIDTH-1:0] next_bits;
    logic [MAX_WIDTH+1:0] up_pad;
    logic [MAX_WIDTH+1:0] mid_pad;
    logic [MAX_WIDTH+1:0] low_pad;
    logic [MAX_WIDTH:0]   head_data;

    // Handshakes
    assign cfg_ready  = 1'b1;
    assign in_ready   = ~flush_reg & fifo_st.room_two;
    assign in_fire    = in_valid & in_ready;
    assign flush_fire = flush_reg & fifo_st.not_full;
    assign push       = flush_fire | (in_fire & held_reg);

    assign ctrl.load  = in_fire;
    assign ctrl.clear = flush_fire;
    assign ctrl.flush = flush_reg;

    // Zero columns outside the grid on both edges
    assign up_pad  = {1'b0, up_tap, 1'b0};
    assign mid_pad = {1'b0, mid_tap, 1'b0};
    assign low_pad = {1'b0, low_tap, 1'b0};

    // Row of column cells
    for (genvar i = 0; i < MAX_WIDTH; i++)
    begin : g_col
        localparam logic [GW_W-1:0] COL_IDX = GW_W'(i);

        ncts_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .en        (COL_IDX < grid_width_reg),
            .below_in  (row_cells[i]),
            .thresh    (thresh_reg),
            .left_up   (up_pad[i]),
            .left_mid  (mid_pad[i]),
            .left_low  (low_pad[i]),
            .right_up  (up_pad[i+2]),
            .right_mid (mid_pad[i+2]),
            .right_low (low_pad[i+2]),
            .up_tap    (up_tap[i]),
            .mid_tap   (mid_tap[i]),
            .low_tap   (low_tap[i]),
            .next_bit  (next_bits[i])
        );
    end

    // Result queue
    ncts_out_fifo
    #(
        .DATA_W (MAX_WIDTH + 1),
        .DEPTH  (ncts_pkg::OUT_DEPTH)
    )
    u_out_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({flush_fire, next_bits}),
        .pop_valid (out_valid),
        .pop_ready (out_ready),
        .pop_data  (head_data),
        .status    (fifo_st)
    );

    assign frame_end      = head_data[MAX_WIDTH];
    assign next_row_cells = ncts_pkg::ROW_BITS'(head_data[MAX_WIDTH-1:0]);

    // Configuration and grid sequencing
    always_comb
    begin
        grid_width_next = grid_width_reg;
        thresh_next     = thresh_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (ncts_pkg::cfg_reg_t'(cfg_index))
                ncts_pkg::REG_GRID_WIDTH:      grid_width_next = cfg_data[GW_W-1:0];
                ncts_pkg::REG_BIRTH_THRESHOLD: thresh_next = cfg_data[ncts_pkg::THRESH_W-1:0];
                default:                       ;
            endcase
        end

        held_next  = held_reg;
        flush_next = flush_reg;
        if (flush_fire)
        begin
            flush_next = 1'b0;
            held_next  = 1'b0;
        end
        else if (in_fire)
        begin
            flush_next = last_row;
            held_next  = ~last_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg <= ncts_pkg::GRID_WIDTH_RST;
            thresh_reg     <= ncts_pkg::THRESH_RST;
            held_reg       <= 1'b0;
            flush_reg      <= 1'b0;
        end
        else
        begin
            grid_width_reg <= grid_width_next;
            thresh_reg     <= thresh_next;
            held_reg       <= held_next;
            flush_reg      <= flush_next;
        end
    end

endmodule

/* hw/rtl/ncts_checker.sv */
`timescale 1ns / 1ps

module ncts_checker
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_ready,
    input logic [ncts_pkg::ROW_BITS-1:0]   row_cells,
    input logic                            last_row,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [ncts_pkg::ROW_BITS-1:0]   next_row_cells,
    input logic                            frame_end,
    input logic                            cfg_valid,
    input logic                            cfg_ready,
    input logic [ncts_pkg::CFG_IDX_W-1:0]  cfg_index,
    input logic [ncts_pkg::CFG_DATA_W-1:0] cfg_data
);

    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(next_row_cells)
                                    && $stable(frame_end))
        else $error("result changed while stalled");

    // The cycle after the last row is the flush cycle: no request taken
    a_flush_gap: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && last_row |=> !in_ready)
        else $error("row accepted during flush");

    // Queue is empty coming out of reset
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result pending after reset");

    // Configuration port never stalls
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

endmodule

bind neighbour_count_threshold_stencil ncts_checker u_ncts_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .row_cells      (row_cells),
    .last_row       (last_row),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .next_row_cells (next_row_cells),
    .frame_end      (frame_end),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
);
